FILE: design/sds_pkg.sv
package sds_pkg;

    localparam int CYL_W  = 16;
    localparam int MOVE_W = 22;

    localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

    // configuration register indexes
    localparam logic CFG_FIRST_DIR = 1'b0;
    localparam logic CFG_END_CYL   = 1'b1;

    // input commands
    localparam logic CMD_SET_HEAD = 1'b0;
    localparam logic CMD_ADD_REQ  = 1'b1;

    localparam logic [CYL_W-1:0] END_CYL_RESET = 16'd199;

    typedef logic [CYL_W-1:0] cyl_t;
    typedef logic [MOVE_W-1:0] move_t;

endpackage

FILE: design/sds_ram.sv
module sds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/scan_disk_scheduler_unit.sv
// scan (elevator) disk scheduler, requests held in one simple dual-port ram
// set-head and non-final add items: accepted one per cycle while idle, no result
// final add item: insertion sort in ram, one compare/shift per step, then a split
// scan over the requests at or below the start, then n+1 results (the requests
// plus the turn-around); next item after that
// reset (aresetn low, synchronous): list empty, head 0, end 199, first sweep down
module scan_disk_scheduler_unit #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    // input items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  sds_pkg::cyl_t        s_cylinder,
    input  logic                 s_is_last,
    // result items
    output logic                 m_valid,
    input  logic                 m_ready,
    output sds_pkg::cyl_t        m_head_position,
    output sds_pkg::move_t       m_total_movement,
    output logic                 m_last_step
);
    import sds_pkg::*;

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REQUESTS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SORT_I = 4'd1;
    localparam logic [3:0] ST_SORT_V = 4'd2;
    localparam logic [3:0] ST_SORT_C = 4'd3;
    localparam logic [3:0] ST_SORT_W = 4'd4;
    localparam logic [3:0] ST_SPL_RD = 4'd5;
    localparam logic [3:0] ST_SPL_C  = 4'd6;
    localparam logic [3:0] ST_NEXT   = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [3:0]    state_reg;
    logic          dir_reg;
    cyl_t          end_reg;
    logic [CW-1:0] cnt_reg;
    cyl_t          start_reg;
    cyl_t          cur_reg;
    move_t         move_reg;
    logic [CW-1:0] i_reg, j_reg;
    cyl_t          v_reg;
    logic [CW-1:0] up_reg, dn_reg;
    logic [1:0]    ph_reg;
    logic          use_mem_reg;
    logic          last_pend_reg;
    logic          m_valid_reg;
    cyl_t          m_pos_reg;
    move_t         m_move_reg;
    logic          m_last_reg;

    // ram port controls
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    cyl_t          ram_wdata, ram_rdata;

    sds_ram #(.WIDTH(CYL_W), .DEPTH(MAX_REQUESTS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic          in_acc;
    cyl_t          sat_cyl;
    logic [CW-1:0] cnt_after;
    logic          up_has, dn_has;
    logic          first_has, second_has;
    cyl_t          emit_pos;
    cyl_t          step_dist;
    logic [MOVE_W:0] move_sum;
    move_t         move_next;
    logic          out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign sat_cyl   = (s_cylinder > end_reg) ? end_reg : s_cylinder;
    assign cnt_after = (cnt_reg < CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    // sides still holding requests, relative to the split point
    assign up_has     = (up_reg < cnt_reg);
    assign dn_has     = (dn_reg != '0);
    assign first_has  = dir_reg ? up_has : dn_has;
    assign second_has = dir_reg ? dn_has : up_has;

    assign emit_pos  = use_mem_reg ? ram_rdata : (dir_reg ? end_reg : '0);
    assign step_dist = (cur_reg > emit_pos) ? cur_reg - emit_pos : emit_pos - cur_reg;
    assign move_sum  = {1'b0, move_reg} + (MOVE_W + 1)'(step_dist);
    assign move_next = move_sum[MOVE_W] ? MOVE_MAX : move_sum[MOVE_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;

    // ram access per state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = v_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ram_we    = in_acc && (s_command == CMD_ADD_REQ) && (cnt_reg < CNT_MAX);
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = sat_cyl;
            end
            ST_SORT_I: begin
                ram_re    = 1'b1;
                ram_raddr = i_reg[AW-1:0];
            end
            ST_SORT_V: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(j_reg - 1'b1);
            end
            ST_SORT_C: begin
                // shift the larger entry up, or drop the held value in place
                ram_we    = 1'b1;
                ram_waddr = j_reg[AW-1:0];
                ram_wdata = (ram_rdata > v_reg) ? ram_rdata : v_reg;
                ram_re    = (ram_rdata > v_reg) && (j_reg > CW'(1));
                ram_raddr = AW'(j_reg - CW'(2));
            end
            ST_SORT_W: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[AW-1:0];
            end
            ST_SPL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = up_reg[AW-1:0];
            end
            ST_NEXT: begin
                ram_re    = 1'b1;
                if ((ph_reg == PH_FIRST) == dir_reg) begin
                    ram_raddr = up_reg[AW-1:0];
                end else begin
                    ram_raddr = AW'(dn_reg - 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dir_reg     <= 1'b0;
            end_reg     <= END_CYL_RESET;
            cnt_reg     <= '0;
            start_reg   <= '0;
            cur_reg     <= '0;
            move_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FIRST_DIR: dir_reg <= cfg_data[0];
                    CFG_END_CYL:   end_reg <= cfg_data;
                endcase
            end
            // the emit state sets valid itself whenever the output frees up
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_command == CMD_SET_HEAD) begin
                            start_reg <= s_cylinder;
                            cur_reg   <= s_cylinder;
                            cnt_reg   <= '0;
                        end else begin
                            cnt_reg <= cnt_after;
                            i_reg   <= CW'(1);
                            if (s_is_last) begin
                                state_reg <= ST_SORT_I;
                            end
                        end
                    end
                end
                ST_SORT_I: begin
                    // read issued here is harmless once the sort is done
                    if (i_reg >= cnt_reg) begin
                        up_reg    <= '0;
                        state_reg <= ST_SPL_RD;
                    end else begin
                        j_reg     <= i_reg;
                        state_reg <= ST_SORT_V;
                    end
                end
                ST_SORT_V: begin
                    v_reg     <= ram_rdata;
                    state_reg <= ST_SORT_C;
                end
                ST_SORT_C: begin
                    if (ram_rdata > v_reg) begin
                        j_reg <= j_reg - 1'b1;
                        if (j_reg == CW'(1)) begin
                            state_reg <= ST_SORT_W;
                        end
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SORT_I;
                    end
                end
                ST_SORT_W: begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= ST_SORT_I;
                end
                ST_SPL_RD: begin
                    if (up_reg >= cnt_reg) begin
                        dn_reg    <= up_reg;
                        ph_reg    <= PH_FIRST;
                        move_reg  <= '0;
                        cur_reg   <= start_reg;
                        state_reg <= ST_NEXT;
                    end else begin
                        state_reg <= ST_SPL_C;
                    end
                end
                ST_SPL_C: begin
                    if (ram_rdata <= start_reg) begin
                        up_reg    <= up_reg + 1'b1;
                        state_reg <= ST_SPL_RD;
                    end else begin
                        dn_reg    <= up_reg;
                        ph_reg    <= PH_FIRST;
                        move_reg  <= '0;
                        cur_reg   <= start_reg;
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    state_reg <= ST_EMIT;
                    priority if (ph_reg == PH_FIRST && first_has) begin
                        use_mem_reg   <= 1'b1;
                        last_pend_reg <= 1'b0;
                        if (dir_reg) up_reg <= up_reg + 1'b1;
                        else         dn_reg <= dn_reg - 1'b1;
                    end else if (ph_reg != PH_SECOND) begin
                        // turn-around at the end cylinder going up, or at cylinder 0 going down
                        use_mem_reg   <= 1'b0;
                        last_pend_reg <= !second_has;
                        ph_reg        <= PH_SECOND;
                    end else begin
                        use_mem_reg <= 1'b1;
                        if (dir_reg) begin
                            dn_reg        <= dn_reg - 1'b1;
                            last_pend_reg <= (dn_reg == CW'(1));
                        end else begin
                            up_reg        <= up_reg + 1'b1;
                            last_pend_reg <= (up_reg + 1'b1 == cnt_reg);
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_pos_reg   <= emit_pos;
                        m_move_reg  <= move_next;
                        m_last_reg  <= last_pend_reg;
                        move_reg    <= move_next;
                        cur_reg     <= emit_pos;
                        if (last_pend_reg) begin
                            cnt_reg   <= '0;
                            start_reg <= emit_pos;
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_head_position  = m_pos_reg;
    assign m_total_movement = m_move_reg;
    assign m_last_step      = m_last_reg;

    // fill count never passes the store depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("request count beyond store depth");

    // sweep pointers stay ordered around the split while results go out
    a_ptr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NEXT || state_reg == ST_EMIT) |->
            (dn_reg <= up_reg) && (up_reg <= cnt_reg))
        else $error("sweep pointers out of order");

    // a final result always returns the block to accepting items
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && last_pend_reg) |=> s_ready)
        else $error("block not idle after final result");

endmodule

FILE: sim/tb_scan_disk_scheduler_unit.sv
module tb_scan_disk_scheduler_unit;
    import sds_pkg::*;

    localparam int MAX_REQ = 32;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_TARGET = 380;

    typedef struct packed {
        cyl_t  head;
        move_t movement;
        logic  last_step;
    } visit_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_FIRST_DIR;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = CMD_SET_HEAD;
    cyl_t        s_cylinder = '0;
    logic        s_is_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    cyl_t        m_head_position;
    move_t       m_total_movement;
    logic        m_last_step;

    // scheduler shadow state
    logic        sweep_up;
    cyl_t        disk_end;
    cyl_t        pending_cyl[$];
    cyl_t        origin;
    visit_t      visit_queue[$];
    int          errors = 0;
    int          cycles = 0;
    int          items_sent = 0;
    int          ready_wait = 0;

    scan_disk_scheduler_unit #(.MAX_REQUESTS(MAX_REQ)) u_top (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // global watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // move the model head to one position and log the expected item
    function automatic void head_to(input cyl_t pos, inout cyl_t cur, inout move_t tot);
        int unsigned d;
        int unsigned t;
        visit_t v;
        d = (pos > cur) ? pos - cur : cur - pos;
        t = tot + d;
        tot = (t > MOVE_MAX) ? MOVE_MAX : t[MOVE_W-1:0];
        cur = pos;
        v.head = pos;
        v.movement = tot;
        v.last_step = 1'b0;
        visit_queue.push_back(v);
    endfunction

    // elevator sweep on the pending list, fills visit_queue
    function automatic void plan_sweep();
        cyl_t  sorted[$];
        cyl_t  cur;
        move_t tot;
        int    split;
        sorted = pending_cyl;
        sorted.sort();
        split = 0;
        while (split < sorted.size() && sorted[split] <= origin)
            split++;
        cur = origin;
        tot = '0;
        if (!sweep_up) begin
            for (int i = split; i > 0; i--) head_to(sorted[i-1], cur, tot);
            head_to('0, cur, tot);
            for (int i = split; i < sorted.size(); i++) head_to(sorted[i], cur, tot);
        end else begin
            for (int i = split; i < sorted.size(); i++) head_to(sorted[i], cur, tot);
            head_to(disk_end, cur, tot);
            for (int i = split; i > 0; i--) head_to(sorted[i-1], cur, tot);
        end
        visit_queue[$].last_step = 1'b1;
        pending_cyl.delete();
        origin = cur;
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge aclk);
    endtask

    // one item on the request channel, model updated at acceptance
    // valid drops only when a gap follows, or when drain takes over
    task automatic send_item(input logic cmd, input cyl_t cyl, input logic last);
        int gap;
        gap = $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            idle_cycles(gap);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_cylinder <= cyl;
        s_is_last <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (cmd == CMD_SET_HEAD) begin
            origin = cyl;
            pending_cyl.delete();
        end else begin
            if (pending_cyl.size() < MAX_REQ)
                pending_cyl.push_back((cyl > disk_end) ? disk_end : cyl);
            if (last)
                plan_sweep();
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (visit_queue.size() != 0) @(posedge aclk);
        idle_cycles(MAX_REQ * MAX_REQ * 3 + 200);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_FIRST_DIR) sweep_up = val[0];
        else disk_end = val;
        @(posedge aclk);
    endtask

    // result stall, a randomly drawn wait per item
    always @(posedge aclk) begin
        int draw;
        draw = $urandom_range(0, 8);
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_wait <= draw;
        end else if (m_valid && m_ready) begin
            m_ready <= (draw == 0);
            ready_wait <= draw;
        end else if (m_valid && !m_ready) begin
            if (ready_wait <= 1) m_ready <= 1'b1;
            ready_wait <= ready_wait - 1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        visit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (visit_queue.size() == 0) begin
                $display("%0t unexpected item head %0d move %0d last %0b", $time,
                         m_head_position, m_total_movement, m_last_step);
                errors++;
            end else begin
                want = visit_queue.pop_front();
                if (m_head_position !== want.head) begin
                    $display("%0t head exp %0d got %0d", $time, want.head, m_head_position);
                    errors++;
                end
                if (m_total_movement !== want.movement) begin
                    $display("%0t movement exp %0d got %0d", $time, want.movement,
                             m_total_movement);
                    errors++;
                end
                if (m_last_step !== want.last_step) begin
                    $display("%0t last exp %0b got %0b", $time, want.last_step, m_last_step);
                    errors++;
                end
            end
        end
    end

    // random batch with n requests
    task automatic random_batch(input int n, input logic wide);
        if ($urandom_range(0, 2) == 0)
            send_item(CMD_SET_HEAD, wide ? cyl_t'($urandom) : cyl_t'($urandom_range(0, 260)), 1'b0);
        for (int i = 0; i < n; i++)
            send_item(CMD_ADD_REQ, wide ? cyl_t'($urandom) : cyl_t'($urandom_range(0, 260)),
                      i == n - 1);
    endtask

    task automatic test_directed();
        // extremes on both directions, equal-to-start, above end
        send_item(CMD_SET_HEAD, 16'd50, 1'b1);
        send_item(CMD_ADD_REQ, 16'd50, 1'b0);
        send_item(CMD_ADD_REQ, 16'hFFFF, 1'b0);
        send_item(CMD_ADD_REQ, 16'd0, 1'b0);
        send_item(CMD_ADD_REQ, 16'd120, 1'b1);
        drain();
        write_cfg(CFG_FIRST_DIR, 16'd1);
        send_item(CMD_SET_HEAD, 16'd10, 1'b0);
        send_item(CMD_ADD_REQ, 16'd3, 1'b0);
        send_item(CMD_ADD_REQ, 16'd10, 1'b1);
        drain();
        // start beyond end, empty far side
        send_item(CMD_SET_HEAD, 16'hFFFF, 1'b0);
        send_item(CMD_ADD_REQ, 16'd199, 1'b1);
        drain();
        write_cfg(CFG_FIRST_DIR, 16'd0);
        send_item(CMD_ADD_REQ, 16'd5, 1'b1);
        drain();
    endtask

    task automatic test_list_full();
        // more than the store holds, last flag on a dropped request
        for (int i = 0; i < MAX_REQ + 3; i++)
            send_item(CMD_ADD_REQ, cyl_t'($urandom_range(0, 199)), i == MAX_REQ + 2);
        drain();
    endtask

    task automatic test_end_extremes();
        write_cfg(CFG_END_CYL, 16'd0);
        random_batch(3, 1'b1);
        drain();
        write_cfg(CFG_END_CYL, 16'hFFFF);
        write_cfg(CFG_FIRST_DIR, 16'd1);
        random_batch(6, 1'b1);
        drain();
        write_cfg(CFG_END_CYL, 16'd1);
        random_batch(4, 1'b1);
        drain();
    endtask

    task automatic test_random();
        while (items_sent < ITEM_TARGET) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAX_REQ) : $urandom_range(1, 8);
            random_batch(n, $urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0) begin
                drain();
                write_cfg(CFG_FIRST_DIR, 16'($urandom_range(0, 1)));
                write_cfg(CFG_END_CYL, ($urandom_range(0, 1) != 0) ?
                          16'($urandom_range(150, 260)) : 16'($urandom));
            end
        end
    endtask

    initial begin
        sweep_up = 1'b0;
        disk_end = END_CYL_RESET;
        origin = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_list_full();
        test_end_extremes();
        test_random();
        drain();
        if (errors == 0 && visit_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/sds_pkg.sv
design/sds_ram.sv
design/scan_disk_scheduler_unit.sv
sim/tb_scan_disk_scheduler_unit.sv
